// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define HSL_ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that stays live through reset.
`define HSL_ASSERT_CLK_NORST(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- hdl/hsl_pkg.sv -----
// Shared types and constants for the HSL to RGB converter.
`timescale 1ns / 1ps

package hsl_pkg;

    localparam int IN_W      = 13;
    localparam int OUT_W     = 8;
    localparam int HUE_LSB   = 0;
    localparam int SAT_LSB   = 13;
    localparam int LIT_LSB   = 26;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // pipeline: clamp, l*s, p/q and ramp slope, slope product, scale to 8 bits
    localparam int STAGES    = 5;
    localparam int ST_CLAMP  = 0;
    localparam int ST_MUL    = 1;
    localparam int ST_RAMP   = 2;
    localparam int ST_PROD   = 3;
    localparam int ST_OUT    = 4;

    typedef struct packed {
        logic [STAGES-1:0] en;
    } pipe_ctl_t;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } chan_t;

endpackage

// ----- hdl/hsl_pipe_ctrl.sv -----
// Valid tracking and per-stage load enables for the conversion pipeline.
`timescale 1ns / 1ps

module hsl_pipe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output hsl_pkg::pipe_ctl_t  ctl
);

    logic [hsl_pkg::STAGES-1:0] valid_reg;
    logic [hsl_pkg::STAGES-1:0] valid_next;
    logic [hsl_pkg::STAGES-1:0] en;

    // a stage loads when empty or when its contents move on
    always_comb begin
        en[hsl_pkg::STAGES-1] = !valid_reg[hsl_pkg::STAGES-1] || m_tready;
        for (int i = hsl_pkg::STAGES - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb begin
        valid_next    = valid_reg;
        if (en[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int i = 1; i < hsl_pkg::STAGES; i++) begin
            if (en[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[hsl_pkg::STAGES-1];
    assign ctl.en   = en;

endmodule

// ----- hdl/hsl_pq.sv -----
// Input clamp and the p/q terms shared by all three channels.
`timescale 1ns / 1ps

module hsl_pq #(
    parameter int FRAC_BITS = 12
) (
    input  logic                          aclk,
    input  hsl_pkg::pipe_ctl_t            ctl,
    input  logic [hsl_pkg::IN_W-1:0]      hue,
    input  logic [hsl_pkg::IN_W-1:0]      saturation,
    input  logic [hsl_pkg::IN_W-1:0]      lightness,
    output logic [FRAC_BITS:0]            hue_o,
    output logic [2*FRAC_BITS-1:0]        e_o,
    output logic [2*FRAC_BITS:0]          p2_o
);

    localparam int HW  = FRAC_BITS + 1;
    localparam int PW  = 2 * HW;
    localparam int CW  = (HW > hsl_pkg::IN_W) ? HW : hsl_pkg::IN_W;
    localparam int ONE = 1 << FRAC_BITS;

    function automatic logic [HW-1:0] clamp_one(input logic [hsl_pkg::IN_W-1:0] v);
        logic [CW-1:0] x;
        x = CW'(v);
        return (x > CW'(ONE)) ? HW'(ONE) : HW'(x);
    endfunction

    logic [HW-1:0]          h0_reg, s0_reg, l0_reg;
    logic [HW-1:0]          h1_reg, s1_reg, l1_reg;
    logic [PW-1:0]          ls1_reg, ls1_next;
    logic                   low1_reg, low1_next;
    logic [2*FRAC_BITS-1:0] e2_reg, e2_next;
    logic [2*FRAC_BITS:0]   p2_reg, p2_next;
    logic [PW-1:0]          e_full, p_full;

    always_ff @(posedge aclk) begin
        if (ctl.en[hsl_pkg::ST_CLAMP]) begin
            h0_reg <= clamp_one(hue);
            s0_reg <= clamp_one(saturation);
            l0_reg <= clamp_one(lightness);
        end
    end

    assign ls1_next  = PW'(l0_reg) * PW'(s0_reg);
    assign low1_next = ({l0_reg, 1'b0} < (HW+1)'(ONE));

    always_ff @(posedge aclk) begin
        if (ctl.en[hsl_pkg::ST_MUL]) begin
            h1_reg   <= h0_reg;
            s1_reg   <= s0_reg;
            l1_reg   <= l0_reg;
            ls1_reg  <= ls1_next;
            low1_reg <= low1_next;
        end
    end

    // e = q - l, so p = l - e and q - p = 2e
    always_comb begin
        e_full  = low1_reg ? ls1_reg
                           : PW'({s1_reg, {FRAC_BITS{1'b0}}}) - ls1_reg;
        p_full  = PW'({l1_reg, {FRAC_BITS{1'b0}}}) - e_full;
        e2_next = e_full[2*FRAC_BITS-1:0];
        p2_next = p_full[2*FRAC_BITS:0];
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[hsl_pkg::ST_RAMP]) begin
            e2_reg <= e2_next;
            p2_reg <= p2_next;
        end
    end

    assign hue_o = h1_reg;
    assign e_o   = e2_reg;
    assign p2_o  = p2_reg;

endmodule

// ----- hdl/hsl_ramp.sv -----
// One color channel: hue ramp slope, product and scale to 8 bits.
`timescale 1ns / 1ps

module hsl_ramp #(
    parameter int FRAC_BITS = 12
) (
    input  logic                       aclk,
    input  hsl_pkg::pipe_ctl_t         ctl,
    input  hsl_pkg::chan_t             chan,
    input  logic [FRAC_BITS:0]         hue_i,
    input  logic [2*FRAC_BITS-1:0]     e_i,
    input  logic [2*FRAC_BITS:0]       p2_i,
    output logic [hsl_pkg::OUT_W-1:0]  value_o
);

    localparam int HW  = FRAC_BITS + 1;
    localparam int TW  = FRAC_BITS + 4;
    localparam int MW  = 2 * FRAC_BITS + HW;
    localparam int NW  = 3 * FRAC_BITS + 2;
    localparam int SW  = NW + 8;
    localparam int RW  = SW - 3 * FRAC_BITS;
    localparam int ONE = 1 << FRAC_BITS;

    localparam logic signed [TW-1:0] ONE_S   = TW'(ONE);
    localparam logic signed [TW-1:0] TWO_S   = TW'(2 * ONE);
    localparam logic signed [TW-1:0] THREE_S = TW'(3 * ONE);
    localparam logic signed [TW-1:0] FOUR_S  = TW'(4 * ONE);
    localparam logic [RW-1:0]        MAX_V   = RW'((1 << hsl_pkg::OUT_W) - 1);

    logic signed [TW-1:0]      off, t3, tw, t2;
    logic [TW-1:0]             h3;
    logic [HW-1:0]             k_reg, k_next;
    logic [MW-1:0]             prod_reg, prod_next;
    logic [2*FRAC_BITS:0]      p3_reg;
    logic [NW-1:0]             num;
    logic [SW-1:0]             scaled;
    logic [RW-1:0]             r;
    logic [hsl_pkg::OUT_W-1:0] value_reg, value_next;

    // slope factor k in [0, ONE]: value = p + (q - p) * k / ONE
    always_comb begin
        case (chan)
            hsl_pkg::CH_RED:   off = ONE_S;
            hsl_pkg::CH_BLUE:  off = -ONE_S;
            default:           off = '0;
        endcase
        h3 = (TW'(hue_i) << 1) + TW'(hue_i);
        t3 = $signed(h3) + off;
        if (t3[TW-1]) begin
            tw = t3 + THREE_S;
        end else if (t3 > THREE_S) begin
            tw = t3 - THREE_S;
        end else begin
            tw = t3;
        end
        t2 = tw <<< 1;
        if (t2 < ONE_S) begin
            k_next = HW'(t2);
        end else if (t2 < THREE_S) begin
            k_next = HW'(ONE);
        end else if (tw < TWO_S) begin
            k_next = HW'(FOUR_S - t2);
        end else begin
            k_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[hsl_pkg::ST_RAMP]) begin
            k_reg <= k_next;
        end
    end

    assign prod_next = MW'(e_i) * MW'(k_reg);

    always_ff @(posedge aclk) begin
        if (ctl.en[hsl_pkg::ST_PROD]) begin
            prod_reg <= prod_next;
            p3_reg   <= p2_i;
        end
    end

    // value in units of 1/ONE^3, times 255, floor
    always_comb begin
        num        = NW'({p3_reg, {FRAC_BITS{1'b0}}}) + NW'({prod_reg, 1'b0});
        scaled     = {num, 8'b0} - SW'(num);
        r          = scaled[SW-1:3*FRAC_BITS];
        value_next = (r > MAX_V) ? '1 : r[hsl_pkg::OUT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[hsl_pkg::ST_OUT]) begin
            value_reg <= value_next;
        end
    end

    assign value_o = value_reg;

endmodule

// ----- hdl/hsl_to_rgb_converter.sv -----
// Top level of the HSL to RGB pixel converter.
`timescale 1ns / 1ps

// Converts one pixel per transfer from hue, saturation and lightness (unsigned
// fractions with FRAC_BITS fraction bits, 1.0 = 1 << FRAC_BITS, larger codes
// clamp to 1.0) to 8-bit red, green and blue, each floor(255 * channel value)
// with exact arithmetic. The block takes one transfer every clock cycle while
// the output side is ready. Five register stages lie between input and output:
// input clamp, the l*s multiplier, the p/q terms with each channel's hue ramp
// slope, the slope multipliers (one per channel), and the scale to 8 bits in
// the output register. Every stage carries its own valid bit and loads whenever
// it is empty or its item moves on, so bubbles are squeezed out and back
// pressure on m_tready holds items in place without loss; s_tready is low only
// while all stages are full and the output is stalled.
module hsl_to_rgb_converter #(
    parameter int FRAC_BITS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [12:0] hue, [25:13] saturation, [38:26] lightness, [39] zero
    input  logic [hsl_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [hsl_pkg::M_TDATA_W-1:0]   m_tdata
);

    hsl_pkg::pipe_ctl_t          ctl;
    logic [hsl_pkg::IN_W-1:0]    hue, saturation, lightness;
    logic [FRAC_BITS:0]          hue_s1;
    logic [2*FRAC_BITS-1:0]      e_s2;
    logic [2*FRAC_BITS:0]        p2_s2;
    logic [hsl_pkg::OUT_W-1:0]   red, green, blue;

    assign hue        = s_tdata[hsl_pkg::HUE_LSB +: hsl_pkg::IN_W];
    assign saturation = s_tdata[hsl_pkg::SAT_LSB +: hsl_pkg::IN_W];
    assign lightness  = s_tdata[hsl_pkg::LIT_LSB +: hsl_pkg::IN_W];

    hsl_pipe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl)
    );

    // p/q terms, shared by the three channels
    hsl_pq #(.FRAC_BITS(FRAC_BITS)) u_pq (
        .aclk       (aclk),
        .ctl        (ctl),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .hue_o      (hue_s1),
        .e_o        (e_s2),
        .p2_o       (p2_s2)
    );

    // red ramp at h + 1/3, green at h, blue at h - 1/3
    hsl_ramp #(.FRAC_BITS(FRAC_BITS)) u_red (
        .aclk    (aclk),
        .ctl     (ctl),
        .chan    (hsl_pkg::CH_RED),
        .hue_i   (hue_s1),
        .e_i     (e_s2),
        .p2_i    (p2_s2),
        .value_o (red)
    );

    hsl_ramp #(.FRAC_BITS(FRAC_BITS)) u_green (
        .aclk    (aclk),
        .ctl     (ctl),
        .chan    (hsl_pkg::CH_GREEN),
        .hue_i   (hue_s1),
        .e_i     (e_s2),
        .p2_i    (p2_s2),
        .value_o (green)
    );

    hsl_ramp #(.FRAC_BITS(FRAC_BITS)) u_blue (
        .aclk    (aclk),
        .ctl     (ctl),
        .chan    (hsl_pkg::CH_BLUE),
        .hue_i   (hue_s1),
        .e_i     (e_s2),
        .p2_i    (p2_s2),
        .value_o (blue)
    );

    assign m_tdata = {blue, green, red};

endmodule

// ----- hdl/hsl_checker.sv -----
// Port-level assertions for the HSL to RGB converter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsl_port_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [hsl_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [hsl_pkg::M_TDATA_W-1:0]   m_tdata
);

    property p_out_hold;
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata);
    endproperty

    property p_reset_empty;
        !aresetn |=> !m_tvalid;
    endproperty

    property p_flow_through;
        m_tready |-> s_tready;
    endproperty

    property p_latency;
        (s_tvalid && s_tready) ##1 m_tready [*4] |=> m_tvalid;
    endproperty

    property p_grey;
        (s_tvalid && s_tready && (s_tdata[hsl_pkg::SAT_LSB +: hsl_pkg::IN_W] == '0))
            ##1 m_tready [*4]
            |=> (m_tdata[0 +: hsl_pkg::OUT_W] == m_tdata[hsl_pkg::OUT_W +: hsl_pkg::OUT_W])
                && (m_tdata[hsl_pkg::OUT_W +: hsl_pkg::OUT_W]
                    == m_tdata[2*hsl_pkg::OUT_W +: hsl_pkg::OUT_W]);
    endproperty

    // stalled output holds
    `HSL_ASSERT_CLK(a_out_hold, aclk, aresetn, p_out_hold, "stalled output changed or dropped")

    // nothing left over after reset
    `HSL_ASSERT_CLK_NORST(a_reset_empty, aclk, p_reset_empty, "output valid right after reset")

    // a ready sink never blocks the input
    `HSL_ASSERT_CLK(a_flow_through, aclk, aresetn, p_flow_through, "input stalled, output ready")

    // without back pressure an item comes out after the fixed latency
    `HSL_ASSERT_CLK(a_latency, aclk, aresetn, p_latency, "result missing after latency")

    // zero saturation gives grey
    `HSL_ASSERT_CLK(a_grey, aclk, aresetn, p_grey, "zero saturation result is not grey")

endmodule

bind hsl_to_rgb_converter hsl_port_checker u_hsl_checker (.*);

// ----- tb/hsl_checker.sv -----
// Monitor and scoreboard for the HSL to RGB converter streams.
`timescale 1ns / 1ps

module hsl_checker #(
    parameter int FRAC_BITS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [12:0] hue, [25:13] saturation, [38:26] lightness, [39] zero
    input  logic [hsl_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    input  logic [hsl_pkg::M_TDATA_W-1:0]   m_tdata,
    output int                              fail_count,
    output int                              pending
);

    localparam longint UNIT = longint'(1) << FRAC_BITS;

    typedef struct packed {
        logic [hsl_pkg::OUT_W-1:0] blue;
        logic [hsl_pkg::OUT_W-1:0] green;
        logic [hsl_pkg::OUT_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic [hsl_pkg::IN_W-1:0] hue;
        logic [hsl_pkg::IN_W-1:0] sat;
        logic [hsl_pkg::IN_W-1:0] lit;
        rgb_t                     rgb;
    } pixel_t;

    pixel_t expected_px[$];
    pixel_t want;
    pixel_t seen;
    rgb_t   got;

    function automatic longint clamp_frac(logic [hsl_pkg::IN_W-1:0] v);
        longint x;
        x = longint'(v);
        return (x > UNIT) ? UNIT : x;
    endfunction

    // t3 in units of 1/(3*UNIT), p2/q2 in units of 1/UNIT^2
    function automatic logic [hsl_pkg::OUT_W-1:0] ramp_level(longint p2, longint q2,
                                                             longint t3);
        longint num;
        longint lvl;
        if (t3 < 0)
            t3 = t3 + 3 * UNIT;
        else if (t3 > 3 * UNIT)
            t3 = t3 - 3 * UNIT;
        if (2 * t3 < UNIT)
            num = p2 * UNIT + (q2 - p2) * 2 * t3;
        else if (2 * t3 < 3 * UNIT)
            num = q2 * UNIT;
        else if (t3 < 2 * UNIT)
            num = p2 * UNIT + (q2 - p2) * (4 * UNIT - 2 * t3);
        else
            num = p2 * UNIT;
        if (num < 0)
            num = 0;
        lvl = (num * 255) / (UNIT * UNIT * UNIT);
        return (lvl > 255) ? 8'd255 : lvl[hsl_pkg::OUT_W-1:0];
    endfunction

    function automatic rgb_t convert_pixel(logic [hsl_pkg::IN_W-1:0] hue,
                                           logic [hsl_pkg::IN_W-1:0] sat,
                                           logic [hsl_pkg::IN_W-1:0] lit);
        longint h;
        longint s;
        longint l;
        longint q2;
        longint p2;
        longint grey;
        rgb_t   c;
        h = clamp_frac(hue);
        s = clamp_frac(sat);
        l = clamp_frac(lit);
        if (s == 0) begin
            grey = (l * 255) / UNIT;
            if (grey > 255)
                grey = 255;
            c.red   = grey[hsl_pkg::OUT_W-1:0];
            c.green = grey[hsl_pkg::OUT_W-1:0];
            c.blue  = grey[hsl_pkg::OUT_W-1:0];
            return c;
        end
        if (2 * l < UNIT)
            q2 = l * (UNIT + s);
        else
            q2 = (l + s) * UNIT - l * s;
        p2 = 2 * l * UNIT - q2;
        c.red   = ramp_level(p2, q2, 3 * h + UNIT);
        c.green = ramp_level(p2, q2, 3 * h);
        c.blue  = ramp_level(p2, q2, 3 * h - UNIT);
        return c;
    endfunction

    task automatic log_fail(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // output side first, so a result can never pair with a same-cycle input
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_px.size() == 0) begin
                    log_fail($sformatf("unexpected result r=%0d g=%0d b=%0d",
                                       got.red, got.green, got.blue));
                end else begin
                    want = expected_px.pop_front();
                    if (got.red !== want.rgb.red || got.green !== want.rgb.green ||
                        got.blue !== want.rgb.blue)
                        log_fail($sformatf(
                            "h=%0d s=%0d l=%0d expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                            want.hue, want.sat, want.lit,
                            want.rgb.red, want.rgb.green, want.rgb.blue,
                            got.red, got.green, got.blue));
                end
            end
            if (s_tvalid && s_tready) begin
                seen.hue = s_tdata[hsl_pkg::HUE_LSB +: hsl_pkg::IN_W];
                seen.sat = s_tdata[hsl_pkg::SAT_LSB +: hsl_pkg::IN_W];
                seen.lit = s_tdata[hsl_pkg::LIT_LSB +: hsl_pkg::IN_W];
                seen.rgb = convert_pixel(seen.hue, seen.sat, seen.lit);
                expected_px.push_back(seen);
            end
            pending = expected_px.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the HSL to RGB converter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC_BITS      = 12;
    localparam int ONE            = 1 << FRAC_BITS;
    localparam int CHUNKS         = 15;
    localparam int CHUNK_ITEMS    = 95;
    localparam int HOLD_CHUNK     = 3;     // receiver held off at the start of this chunk
    localparam int DRAIN_CHUNK    = 8;     // sender drains the block before this chunk
    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 1000;

    // s_tdata layout, lowest field last: hue in the low bits, a zero pad on top
    typedef struct packed {
        logic                     pad;
        logic [hsl_pkg::IN_W-1:0] lightness;
        logic [hsl_pkg::IN_W-1:0] saturation;
        logic [hsl_pkg::IN_W-1:0] hue;
    } hsl_word_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [hsl_pkg::S_TDATA_W-1:0]  s_tdata;   // [12:0] hue, [25:13] saturation, [38:26] lightness
    logic                           m_tvalid;
    logic                           m_tready;
    logic [hsl_pkg::M_TDATA_W-1:0]  m_tdata;   // [7:0] red, [15:8] green, [23:16] blue

    int  fail_count;
    int  pending;
    int  idle_cycles;
    int  hold_req;                      // long hold-offs requested by stimulus
    bit  tx_idle_en;
    bit  rx_idle_en;

    hsl_to_rgb_converter #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hsl_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) rgb_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Idle stretch length: mostly a few cycles, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 30));
    endfunction

    // Fraction code: zero, one, above one (clamps), ramp breakpoints, or uniform.
    function automatic int rand_frac();
        int sel;
        sel = int'($urandom_range(0, 99));
        if (sel < 8)
            return 0;
        if (sel < 16)
            return ONE;
        if (sel < 24)
            return int'($urandom_range(ONE + 1, (1 << hsl_pkg::IN_W) - 1));
        if (sel < 32) begin
            case ($urandom_range(0, 7))
                0: return 682;       // just under 1/6
                1: return 683;       // just over 1/6
                2: return 1365;      // around 1/3
                3: return 1366;
                4: return 2047;      // just under one half
                5: return 2048;      // exactly one half
                6: return 2731;      // just over 2/3
                default: return 1;
            endcase
        end
        return int'($urandom_range(0, ONE));
    endfunction

    // One input transfer. Valid only drops when a gap is taken, so back-to-back
    // items keep tvalid high across the boundary. Returns at the falling edge
    // after acceptance with tvalid still high.
    task automatic send_pixel(input int hue, input int sat, input int lit);
        hsl_word_t   w;
        int          gap;
        logic [63:0] junk;
        gap = (tx_idle_en && $urandom_range(0, 99) < 20) ? idle_len() : 0;
        if (gap > 0) begin
            junk     = {$urandom, $urandom};
            s_tvalid = 1'b0;
            s_tdata  = junk[hsl_pkg::S_TDATA_W-1:0];   // junk while idle
            repeat (gap) @(negedge aclk);
        end
        w.pad        = 1'b0;
        w.lightness  = lit[hsl_pkg::IN_W-1:0];
        w.saturation = sat[hsl_pkg::IN_W-1:0];
        w.hue        = hue[hsl_pkg::IN_W-1:0];
        s_tdata      = w;
        s_tvalid     = 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Receiver: random stalls while enabled, plus a long hold-off on request.
    initial begin : receiver
        int stall_left;
        int hold_seen;
        stall_left = 0;
        hold_seen  = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                stall_left = HOLD_CYCLES;
                hold_seen  = hold_req;
            end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 99) < 15) begin
                stall_left = idle_len();
            end
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Watchdog: ends the run when no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int h;
        int s;
        int l;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        aresetn     = 1'b0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Directed corners: hue, saturation, lightness
        send_pixel(0, 0, 0);                // all zero
        send_pixel(8191, 8191, 8191);       // every input bit set, all clamp to one
        send_pixel(ONE, ONE, ONE);          // all exactly one
        send_pixel(4097, 4097, 4097);       // just above one
        send_pixel(1234, 0, 0);             // grey: black
        send_pixel(1234, 0, 2048);          // grey: mid
        send_pixel(1234, 0, ONE);           // grey: white
        send_pixel(2000, 0, 6000);          // grey with clamped lightness
        send_pixel(0, ONE, 2048);           // pure red, blue argument wraps up
        send_pixel(ONE, ONE, 2048);         // green argument lands exactly on one
        send_pixel(682, ONE, 2048);         // first ramp breakpoint
        send_pixel(683, ONE, 2048);
        send_pixel(1365, ONE, 2048);        // blue argument near zero
        send_pixel(1366, ONE, 2048);
        send_pixel(2048, ONE, 2047);        // lightness just below half
        send_pixel(2731, ONE, 2048);        // around 2/3
        send_pixel(2730, 2048, 1024);
        send_pixel(3413, ONE, 2048);        // 5/6, red argument wraps down
        send_pixel(3500, 1, 4095);          // smallest nonzero saturation
        send_pixel(5000, 3000, 1000);       // hue above one
        send_pixel(100, 6000, 3000);        // saturation above one
        send_pixel(4095, ONE, 1);
        send_pixel(2048, 2048, 2049);
        send_pixel(1, ONE, ONE);            // white at full saturation

        // Random chunks, each with its own idling mix
        for (int c = 0; c < CHUNKS; c++) begin
            tx_idle_en = ($urandom_range(0, 2) != 0);
            rx_idle_en = ($urandom_range(0, 2) != 0);
            if (c == HOLD_CHUNK) begin
                // sender keeps streaming into a stalled output until s_tready drops
                tx_idle_en = 1'b0;
                hold_req   = hold_req + 1;
            end
            if (c == DRAIN_CHUNK) begin
                s_tvalid = 1'b0;
                wait (pending == 0);
                @(negedge aclk);
            end
            for (int i = 0; i < CHUNK_ITEMS; i++) begin
                h = rand_frac();
                s = ($urandom_range(0, 9) == 0) ? 0 : rand_frac();
                l = rand_frac();
                send_pixel(h, s, l);
            end
        end
        s_tvalid = 1'b0;

        wait (pending == 0);
        repeat (hsl_pkg::STAGES * 4) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/hsl_pkg.sv
hdl/hsl_pipe_ctrl.sv
hdl/hsl_pq.sv
hdl/hsl_ramp.sv
hdl/hsl_to_rgb_converter.sv
hdl/hsl_checker.sv
tb/hsl_checker.sv
tb/testbench.sv
